### rtl/core/tce_pkg.sv
// Package for the text console engine: geometry, field widths, codes and the
// transaction structs. Used by text_console_engine and the bench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tce_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int CELL_W  = $clog2(CELLS);
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int IDX_W   = 11;
	localparam int BYTE_W  = 8;
	localparam int DATA_W  = 2 * BYTE_W;

	localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'h20;
	localparam logic [BYTE_W-1:0] COLOR_RESET  = 8'h07;

	typedef enum logic [1:0] {
		OP_PUT_CHAR = 2'd0,
		OP_PUT_CELL = 2'd1,
		OP_READ     = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [BYTE_W-1:0] char_code;
		logic [BYTE_W-1:0] cell_color;
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  row;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0]  cursor_index;
		logic [BYTE_W-1:0] read_char;
		logic [BYTE_W-1:0] read_attr;
	} out_t;

	// linear cell address: row * COLUMNS + column
	function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		return CELL_W'(int'(r) * COLUMNS + int'(c));
	endfunction

endpackage

`default_nettype wire

### rtl/core/tce_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module tce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/text_console_engine.sv
// Text console engine: 80x25 screen of 16-bit cells in one RAM, cursor and
// sequencer. Depends on tce_pkg and tce_ram.
//
// Put char, put cell, read cell and newline without a scroll pass from acceptance
// through S_EXEC and S_DONE into the output register. Scroll and clear walk the
// whole screen store, one cell per cycle over the single RAM write port, through
// S_WALK and S_DRAIN. One transaction is in work at a time; the next is taken
// once the result sits in the output register. Reset (arst_n low) clears the
// cursor to 0,0, text_color to 7 and all control state; the screen store is not
// cleared and holds garbage until written by a put or a clear.
`timescale 1ns / 1ps
`default_nettype none

module text_console_engine (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration: text_color
	input  wire logic                        cfg_we,
	input  wire logic [tce_pkg::BYTE_W-1:0]  cfg_wdata,
	// input transactions
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire tce_pkg::in_t                in_data,
	// result transactions
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output tce_pkg::out_t                    out_data
);

	import tce_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t             state_q;
	in_t                item_q;
	logic [BYTE_W-1:0]  text_color_q;
	logic [ROW_W-1:0]   cur_row_q;
	logic [COL_W-1:0]   cur_col_q;
	logic [CELL_W-1:0]  walk_q;
	logic               clear_mode_q;   // 1: clear walk, 0: scroll walk
	logic               out_valid_q;
	out_t               out_q;

	// write stage of the screen walk, in the cycle after the read
	logic               wvld_s1;
	logic               copy_s1;
	logic [CELL_W-1:0]  waddr_s1;

	// RAM ports
	logic               ram_we;
	logic [CELL_W-1:0]  ram_waddr;
	logic [DATA_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [CELL_W-1:0]  ram_raddr;
	logic [DATA_W-1:0]  ram_rdata;

	logic               item_in_range;
	logic               is_newline;
	logic               row_last;
	logic               col_last;
	logic               walk_copy;
	logic               walk_end;
	logic [DATA_W-1:0]  fill_cell;

	assign item_in_range = (item_q.column < COL_W'(COLUMNS)) && (item_q.row < ROW_W'(ROWS));
	assign is_newline    = (item_q.char_code == NEWLINE_CODE);
	assign row_last      = (cur_row_q == ROW_W'(ROWS - 1));
	assign col_last      = (cur_col_q == COL_W'(COLUMNS - 1));
	// rows 1..ROWS-1 move up; the last row is blanked
	assign walk_copy     = (walk_q < CELL_W'(CELLS - COLUMNS));
	assign walk_end      = (walk_q == CELL_W'(CELLS - 1));
	assign fill_cell     = clear_mode_q ? {text_color_q, SPACE_CODE} : {8'h00, SPACE_CODE};

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// RAM access: the walk write stage owns the write port when active,
	// otherwise the single-cell ops in S_EXEC use it
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (wvld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = waddr_s1;
			ram_wdata = copy_s1 ? ram_rdata : fill_cell;
		end else if (state_q == S_EXEC) begin
			case (item_q.operation)
				OP_PUT_CHAR: begin
					if (is_newline) begin
						// blank at start of next row, if it exists
						ram_we    = !row_last;
						ram_waddr = cell_addr(cur_row_q + ROW_W'(1), '0);
						ram_wdata = {text_color_q, SPACE_CODE};
					end else begin
						ram_we    = 1'b1;
						ram_waddr = cell_addr(cur_row_q, cur_col_q);
						ram_wdata = {text_color_q, item_q.char_code};
					end
				end
				OP_PUT_CELL: begin
					ram_we    = item_in_range;
					ram_waddr = cell_addr(item_q.row, item_q.column);
					ram_wdata = {item_q.cell_color, item_q.char_code};
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_EXEC && item_q.operation == OP_READ) begin
			ram_re    = item_in_range;
			ram_raddr = cell_addr(item_q.row, item_q.column);
		end else if (state_q == S_WALK) begin
			ram_re    = walk_copy && !clear_mode_q;
			ram_raddr = walk_q + CELL_W'(COLUMNS);
		end
	end

	tce_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			text_color_q <= COLOR_RESET;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			walk_q       <= '0;
			clear_mode_q <= 1'b0;
			out_valid_q  <= 1'b0;
			wvld_s1      <= 1'b0;
			copy_s1      <= 1'b0;
			waddr_s1     <= '0;
			item_q       <= '0;
			out_q        <= '0;
		end else begin
			if (cfg_we) begin
				text_color_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			wvld_s1 <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (item_q.operation)
						OP_PUT_CHAR: begin
							if (is_newline || col_last) begin
								cur_col_q <= '0;
								if (row_last) begin
									// past the last row: scroll
									clear_mode_q <= 1'b0;
									walk_q       <= '0;
									state_q      <= S_WALK;
								end else begin
									cur_row_q <= cur_row_q + ROW_W'(1);
								end
							end else begin
								cur_col_q <= cur_col_q + COL_W'(1);
							end
						end
						OP_CLEAR: begin
							cur_row_q    <= '0;
							cur_col_q    <= '0;
							clear_mode_q <= 1'b1;
							walk_q       <= '0;
							state_q      <= S_WALK;
						end
						default: begin
						end
					endcase
				end
				S_WALK: begin
					wvld_s1  <= 1'b1;
					copy_s1  <= walk_copy && !clear_mode_q;
					waddr_s1 <= walk_q;
					walk_q   <= walk_q + CELL_W'(1);
					if (walk_end) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// last walk write lands this cycle
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q        <= 1'b1;
						out_q.cursor_index <= IDX_W'(cell_addr(cur_row_q, cur_col_q));
						if (item_q.operation == OP_READ && item_in_range) begin
							out_q.read_char <= ram_rdata[BYTE_W-1:0];
							out_q.read_attr <= ram_rdata[DATA_W-1:BYTE_W];
						end else begin
							out_q.read_char <= '0;
							out_q.read_attr <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### bench/text_console_engine_test.sv
// Self-checking bench for text_console_engine: puts, put-cell, reads, clears,
// line wrap, newline and scroll, with and without random stalls on both channels.
// Depends on tce_pkg and the RTL of the block; needs nothing else.
`timescale 1ns / 1ps

module text_console_engine_test;

	import tce_pkg::*;

	// cycles without any accepted transaction before the run is declared hung;
	// a clear or a scroll alone holds the input while it walks the whole screen
	localparam int IDLE_LIMIT = 20000;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  cfg_we    = 1'b0;
	logic  [BYTE_W-1:0] cfg_wdata = '0;
	logic  in_valid  = 1'b0;
	logic  in_stall;
	in_t   in_data   = '0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	out_t  out_data;

	// chance per cycle, in percent, that each side holds off
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// shadow copy of the console: screen, cursor and the color register
	logic [DATA_W-1:0] shadow_screen [CELLS];
	logic [ROW_W-1:0]  shadow_row;
	logic [COL_W-1:0]  shadow_col;
	logic [BYTE_W-1:0] console_color;

	// expected result transactions, oldest first
	out_t pending_results [$];
	out_t want;
	int   mismatch_count = 0;
	int   quiet_cycles   = 0;

	text_console_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	function automatic logic [DATA_W-1:0] cell_word(input logic [BYTE_W-1:0] ch,
		input logic [BYTE_W-1:0] attr);
		return {attr, ch};
	endfunction

	function automatic in_t make_item(input op_t op, input int unsigned ch,
		input int unsigned color, input int unsigned col, input int unsigned row);
		in_t it;
		it.operation  = op;
		it.char_code  = BYTE_W'(ch);
		it.cell_color = BYTE_W'(color);
		it.column     = COL_W'(col);
		it.row        = ROW_W'(row);
		return it;
	endfunction

	// any character except newline, so a run of them walks along a row
	function automatic int unsigned plain_char();
		int unsigned ch;
		ch = $urandom_range(0, 255);
		if (ch == NEWLINE_CODE)
			ch = SPACE_CODE;
		return ch;
	endfunction

	// Advance the shadow console by one accepted transaction and queue the
	// result it must produce.
	task automatic predict_console(input in_t item);
		out_t res;
		logic [DATA_W-1:0] word;
		res = '0;
		case (op_t'(item.operation))
			OP_PUT_CHAR: begin
				if (item.char_code == NEWLINE_CODE) begin
					// newline blanks the first cell of the new row, if it exists
					shadow_col = '0;
					shadow_row = shadow_row + 1'b1;
					if (shadow_row < ROWS)
						shadow_screen[int'(shadow_row) * COLUMNS] =
							cell_word(SPACE_CODE, console_color);
				end else begin
					shadow_screen[int'(shadow_row) * COLUMNS + int'(shadow_col)] =
						cell_word(item.char_code, console_color);
					shadow_col = shadow_col + 1'b1;
					if (shadow_col >= COLUMNS) begin
						shadow_col = '0;
						shadow_row = shadow_row + 1'b1;
					end
				end
				// past the last row: scroll up, last row becomes blanks with attr 0
				if (shadow_row >= ROWS) begin
					for (int i = 0; i < CELLS - COLUMNS; i++)
						shadow_screen[i] = shadow_screen[i + COLUMNS];
					for (int i = CELLS - COLUMNS; i < CELLS; i++)
						shadow_screen[i] = cell_word(SPACE_CODE, '0);
					shadow_row = ROW_W'(ROWS - 1);
					shadow_col = '0;
				end
			end
			OP_PUT_CELL: begin
				// out-of-range position: the write is dropped
				if (item.column < COLUMNS && item.row < ROWS)
					shadow_screen[int'(item.row) * COLUMNS + int'(item.column)] =
						cell_word(item.char_code, item.cell_color);
			end
			OP_READ: begin
				// out-of-range position reads as zero
				if (item.column < COLUMNS && item.row < ROWS) begin
					word = shadow_screen[int'(item.row) * COLUMNS + int'(item.column)];
					res.read_char = word[BYTE_W-1:0];
					res.read_attr = word[DATA_W-1:BYTE_W];
				end
			end
			default: begin
				for (int i = 0; i < CELLS; i++)
					shadow_screen[i] = cell_word(SPACE_CODE, console_color);
				shadow_row = '0;
				shadow_col = '0;
			end
		endcase
		res.cursor_index = IDX_W'(int'(shadow_row) * COLUMNS + int'(shadow_col));
		pending_results.push_back(res);
	endtask

	// Present one input transaction and hold it until accepted. in_valid is left
	// high so back-to-back transactions need no extra assignment in one step.
	task automatic send_item(input in_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_console(item);
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic drain_console();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// The color register is only written with the block idle.
	task automatic write_text_color(input logic [BYTE_W-1:0] color);
		drain_console();
		cfg_we    <= 1'b1;
		cfg_wdata <= color;
		@(posedge clk);
		cfg_we        <= 1'b0;
		console_color  = color;
	endtask

	// First a clear, so no cell is ever read before it was written.
	task automatic test_reset_and_clear();
		send_item(make_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
		send_item(make_item(OP_READ, $urandom, $urandom, 0, 0));
		send_item(make_item(OP_READ, $urandom, $urandom, COLUMNS - 1, ROWS - 1));
	endtask

	// Put-cell and read at the corners and outside the screen.
	task automatic test_cell_extremes();
		send_item(make_item(OP_PUT_CELL, 8'h00, 8'h00, 0, 0));
		send_item(make_item(OP_PUT_CELL, 8'hFF, 8'hFF, COLUMNS - 1, ROWS - 1));
		send_item(make_item(OP_PUT_CELL, 8'h55, 8'hAA, COLUMNS, 0));
		send_item(make_item(OP_PUT_CELL, 8'hAA, 8'h55, 127, 31));
		send_item(make_item(OP_PUT_CELL, 8'h12, 8'h34, 0, ROWS));
		send_item(make_item(OP_READ, $urandom, $urandom, 0, 0));
		send_item(make_item(OP_READ, $urandom, $urandom, COLUMNS - 1, ROWS - 1));
		send_item(make_item(OP_READ, $urandom, $urandom, COLUMNS - 1, 0));
		send_item(make_item(OP_READ, $urandom, $urandom, 127, 31));
	endtask

	// Put-char with the byte extremes and a newline, then read them back.
	task automatic test_put_char_basics();
		send_item(make_item(OP_PUT_CHAR, 8'h00, $urandom, $urandom, $urandom));
		send_item(make_item(OP_PUT_CHAR, 8'hFF, $urandom, $urandom, $urandom));
		send_item(make_item(OP_PUT_CHAR, NEWLINE_CODE, $urandom, $urandom, $urandom));
		send_item(make_item(OP_PUT_CHAR, 8'h41, $urandom, $urandom, $urandom));
		send_item(make_item(OP_READ, $urandom, $urandom, 0, 0));
		send_item(make_item(OP_READ, $urandom, $urandom, 1, 0));
		send_item(make_item(OP_READ, $urandom, $urandom, 0, 1));
		send_item(make_item(OP_READ, $urandom, $urandom, 1, 1));
	endtask

	// Color register at both extremes: put-char, newline blank and clear use it.
	task automatic test_text_color();
		write_text_color(8'h00);
		send_item(make_item(OP_PUT_CHAR, 8'h7E, $urandom, $urandom, $urandom));
		send_item(make_item(OP_READ, $urandom, $urandom, 2, 1));
		write_text_color(8'hFF);
		send_item(make_item(OP_PUT_CHAR, NEWLINE_CODE, $urandom, $urandom, $urandom));
		send_item(make_item(OP_READ, $urandom, $urandom, 0, 2));
		send_item(make_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
		send_item(make_item(OP_READ, $urandom, $urandom, 40, 12));
	endtask

	// Fill the rest of the current row so the cursor wraps at the line end;
	// on the last row the wrap scrolls, and the filled row is still the one
	// just above the cursor.
	task automatic test_line_wrap();
		send_item(make_item(OP_PUT_CHAR, plain_char(), $urandom, $urandom, $urandom));
		while (shadow_col != 0)
			send_item(make_item(OP_PUT_CHAR, plain_char(), $urandom, $urandom, $urandom));
		send_item(make_item(OP_READ, $urandom, $urandom, COLUMNS - 1, shadow_row - 1'b1));
		send_item(make_item(OP_READ, $urandom, $urandom, 0, shadow_row));
	endtask

	// Newlines down to the last row, a partial line, then one more newline
	// to scroll; the old last row moves up and the new one is blank.
	task automatic test_scroll();
		while (shadow_row != ROWS - 1)
			send_item(make_item(OP_PUT_CHAR, NEWLINE_CODE, $urandom, $urandom, $urandom));
		repeat (3)
			send_item(make_item(OP_PUT_CHAR, plain_char(), $urandom, $urandom, $urandom));
		send_item(make_item(OP_PUT_CHAR, NEWLINE_CODE, $urandom, $urandom, $urandom));
		send_item(make_item(OP_READ, $urandom, $urandom, 1, ROWS - 2));
		send_item(make_item(OP_READ, $urandom, $urandom, 0, ROWS - 1));
		send_item(make_item(OP_READ, $urandom, $urandom, COLUMNS - 1, ROWS - 1));
	endtask

	// Mixed traffic: mostly puts and reads of written cells, some positions
	// out of range, rare clears, and a new color now and then.
	task automatic test_random_traffic(input int count);
		int pick;
		logic [ROW_W-1:0] r;
		logic [COL_W-1:0] c;
		for (int k = 0; k < count; k++) begin
			if (k > 0 && k % 150 == 0)
				write_text_color(BYTE_W'($urandom_range(0, 255)));
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				if ($urandom_range(0, 99) < 12)
					send_item(make_item(OP_PUT_CHAR, NEWLINE_CODE, $urandom, $urandom,
						$urandom));
				else
					send_item(make_item(OP_PUT_CHAR, $urandom_range(0, 255), $urandom,
						$urandom, $urandom));
			end else if (pick < 65) begin
				if ($urandom_range(0, 99) < 90)
					send_item(make_item(OP_PUT_CELL, $urandom, $urandom,
						$urandom_range(0, COLUMNS - 1), $urandom_range(0, ROWS - 1)));
				else
					send_item(make_item(OP_PUT_CELL, $urandom, $urandom,
						$urandom_range(0, 127), $urandom_range(0, 31)));
			end else if (pick < 98) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					// the cell just behind the cursor, i.e. the last put-char
					if (shadow_col != 0) begin
						r = shadow_row;
						c = shadow_col - 1'b1;
					end else if (shadow_row != 0) begin
						r = shadow_row - 1'b1;
						c = COL_W'(COLUMNS - 1);
					end else begin
						r = '0;
						c = '0;
					end
					send_item(make_item(OP_READ, $urandom, $urandom, c, r));
				end else if (pick < 85) begin
					send_item(make_item(OP_READ, $urandom, $urandom,
						$urandom_range(0, COLUMNS - 1), $urandom_range(0, ROWS - 1)));
				end else begin
					send_item(make_item(OP_READ, $urandom, $urandom,
						$urandom_range(0, 127), $urandom_range(0, 31)));
				end
			end else begin
				send_item(make_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
			end
		end
	endtask

	// Result side: check every accepted result transaction against the oldest
	// expectation, then pick the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: index %0d char %02h attr %02h",
					$time, out_data.cursor_index, out_data.read_char, out_data.read_attr);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.cursor_index !== want.cursor_index) begin
					$display("%0t: cursor_index expected %0d actual %0d",
						$time, want.cursor_index, out_data.cursor_index);
					mismatch_count++;
				end
				if (out_data.read_char !== want.read_char) begin
					$display("%0t: read_char expected %02h actual %02h",
						$time, want.read_char, out_data.read_char);
					mismatch_count++;
				end
				if (out_data.read_attr !== want.read_attr) begin
					$display("%0t: read_attr expected %02h actual %02h",
						$time, want.read_attr, out_data.read_attr);
					mismatch_count++;
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Watchdog: too long without any transaction on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		// shadow state as the block comes out of reset
		for (int i = 0; i < CELLS; i++)
			shadow_screen[i] = '0;
		shadow_row    = '0;
		shadow_col    = '0;
		console_color = COLOR_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// phase 1: sender idles now and then, receiver stalls a lot
		send_idle_pct = 22;
		recv_idle_pct = 55;
		test_reset_and_clear();
		test_cell_extremes();
		test_put_char_basics();
		test_text_color();
		test_line_wrap();
		test_scroll();
		test_random_traffic(280);

		// phase 2: the other way round
		write_text_color(8'h00);
		send_idle_pct = 55;
		recv_idle_pct = 22;
		test_line_wrap();
		test_scroll();
		test_random_traffic(280);

		// phase 3: full rate on both sides
		write_text_color(8'hFF);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_scroll();
		test_random_traffic(280);

		// let the last results come back, then wait for strays before the verdict
		drain_console();
		repeat (12) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
